// ===== rtl/core/aps_pkg.sv =====
// Shared types and codes for the aging priority scheduler.
package aps_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SELECT = 3'd1,
    OP_MOVE   = 3'd2,
    OP_REMOVE = 3'd3,
    OP_SETPRI = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  localparam logic signed [7:0] DYN_FLOOR = 8'sh80;

  typedef struct packed {
    logic [7:0]        id;
    logic signed [5:0] stat;
    logic signed [7:0] dyn;
  } entry_t;

  // Search wave handed from cell to cell: best or first-matching entry so far.
  typedef struct packed {
    logic   found;
    entry_t ent;
  } wave_t;

  // Broadcast command; act is high for one cycle when a successful item commits.
  typedef struct packed {
    logic              act;
    logic [2:0]        op;
    logic [7:0]        task_id;
    logic signed [5:0] prio;
  } cmd_t;

endpackage

// ===== rtl/core/aps_cell.sv =====
// One ready-list slot: holds an entry, forwards the search wave, applies commits.
module aps_cell #(
  parameter int MAX_TASKS = 16,
  parameter int IDX       = 0
) (
  input  logic                             clk,
  input  aps_pkg::cmd_t                    cmd,
  input  logic [$clog2(MAX_TASKS+1)-1:0]   count,
  input  logic [$clog2(MAX_TASKS)-1:0]     sel_idx,
  input  logic [$clog2(MAX_TASKS)-1:0]     last_idx,
  input  aps_pkg::entry_t                  carry,
  input  aps_pkg::entry_t                  nbr,
  output aps_pkg::entry_t                  ent,
  input  aps_pkg::wave_t                   wave_in,
  input  logic [$clog2(MAX_TASKS)-1:0]     wave_in_idx,
  output aps_pkg::wave_t                   wave_out,
  output logic [$clog2(MAX_TASKS)-1:0]     wave_out_idx
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [IW-1:0] MY_I = IW'(IDX);
  localparam logic [CW-1:0] MY_C = CW'(IDX);

  aps_pkg::entry_t ent_r, ent_nxt;
  aps_pkg::wave_t  wave_r, wave_nxt;
  logic [IW-1:0]   widx_r, widx_nxt;
  logic            valid;
  logic            take;

  assign valid = (MY_C < count);

  always_comb begin
    take = 1'b0;
    if (cmd.op == aps_pkg::OP_SELECT) begin
      take = valid && (!wave_in.found || (ent_r.dyn < wave_in.ent.dyn));
    end else begin
      take = valid && !wave_in.found && (ent_r.id == cmd.task_id);
    end
    if (take) begin
      wave_nxt.found = 1'b1;
      wave_nxt.ent   = ent_r;
      widx_nxt       = MY_I;
    end else begin
      wave_nxt = wave_in;
      widx_nxt = wave_in_idx;
    end
  end

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.act) begin
      case (cmd.op)
        aps_pkg::OP_ADD: begin
          if (MY_C == count) begin
            ent_nxt.id   = cmd.task_id;
            ent_nxt.stat = cmd.prio;
            ent_nxt.dyn  = {{2{cmd.prio[5]}}, cmd.prio};
          end
        end
        aps_pkg::OP_SELECT: begin
          if (valid) begin
            if (MY_I == sel_idx) begin
              ent_nxt.dyn = {{2{ent_r.stat[5]}}, ent_r.stat};
            end else if (ent_r.dyn != aps_pkg::DYN_FLOOR) begin
              ent_nxt.dyn = ent_r.dyn - 8'sd1;
            end
          end
        end
        aps_pkg::OP_MOVE: begin
          if (MY_I >= sel_idx && MY_I < last_idx) begin
            ent_nxt = nbr;
          end else if (MY_I == last_idx) begin
            ent_nxt = carry;
          end
        end
        aps_pkg::OP_REMOVE: begin
          // close the gap toward the head
          if (MY_I >= sel_idx && MY_I < last_idx) begin
            ent_nxt = nbr;
          end
        end
        aps_pkg::OP_SETPRI: begin
          if (MY_I == sel_idx) begin
            ent_nxt.stat = cmd.prio;
            ent_nxt.dyn  = {{2{cmd.prio[5]}}, cmd.prio};
          end
        end
        default: begin
          ent_nxt = ent_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    wave_r <= wave_nxt;
    widx_r <= widx_nxt;
  end

  assign ent          = ent_r;
  assign wave_out     = wave_r;
  assign wave_out_idx = widx_r;

endmodule

// ===== rtl/core/aging_priority_scheduler_core.sv =====
// Top level of the aging priority scheduler: command sequencer over a chain of slot cells.
//
//   channel | direction | ports
//   --------+-----------+------------------------------------------------
//   in      | input     | in_valid, in_ready, in_operation, in_task_id,
//           |           | in_priority_req
//   out     | output    | out_valid, out_ready, out_status, out_chosen_id,
//           |           | out_chosen_priority
//
// Add: the item goes from accept straight to the commit state; it needs no search.
// Other items: the item passes through the scan state while the search wave advances
// one cell per cycle along the chain, then goes to the commit state.
// One item is in work at a time; a new item is taken while a result waits in
// the output register. A stalled output holds the commit until the result is taken.
// Reset clears the entry count and control; slot contents are not cleared.
module aging_priority_scheduler_core #(
  parameter int MAX_TASKS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_operation,
  input  logic [7:0]        in_task_id,
  input  logic signed [5:0] in_priority_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [7:0]        out_chosen_id,
  output logic signed [5:0] out_chosen_priority
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TASKS);
  localparam logic [IW-1:0] SCAN_LAST  = IW'(MAX_TASKS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t            state_r;
  logic [2:0]        op_r;
  logic [7:0]        id_r;
  logic signed [5:0] prio_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     scan_cnt_r;
  logic              out_valid_r;
  logic [1:0]        status_r;
  logic [7:0]        chosen_id_r;
  logic signed [5:0] chosen_prio_r;

  aps_pkg::entry_t ent_w  [MAX_TASKS];
  aps_pkg::wave_t  wave_w [MAX_TASKS+1];
  logic [IW-1:0]   widx_w [MAX_TASKS+1];

  aps_pkg::cmd_t   cmd;
  logic            can_out;
  logic            success;
  aps_pkg::status_e status_c;
  logic [IW-1:0]   last_idx;
  aps_pkg::wave_t  result;

  assign wave_w[0] = '0;
  assign widx_w[0] = '0;
  assign result    = wave_w[MAX_TASKS];
  assign last_idx  = IW'(count_r - 1'b1);
  assign can_out   = !out_valid_r || out_ready;

  always_comb begin
    status_c = aps_pkg::ST_OK;
    case (op_r)
      aps_pkg::OP_ADD: begin
        if (count_r == FULL_COUNT) status_c = aps_pkg::ST_FULL;
      end
      aps_pkg::OP_SELECT: begin
        if (count_r == '0) status_c = aps_pkg::ST_EMPTY;
      end
      aps_pkg::OP_MOVE, aps_pkg::OP_REMOVE, aps_pkg::OP_SETPRI: begin
        if (!result.found) status_c = aps_pkg::ST_NOT_FOUND;
      end
      default: begin
        status_c = aps_pkg::ST_OK;
      end
    endcase
  end

  assign success = (status_c == aps_pkg::ST_OK);

  always_comb begin
    cmd.act     = (state_r == S_COMMIT) && can_out && success;
    cmd.op      = op_r;
    cmd.task_id = id_r;
    cmd.prio    = prio_r;
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.act) begin
      if (op_r == aps_pkg::OP_ADD) begin
        count_nxt = count_r + 1'b1;
      end else if (op_r == aps_pkg::OP_REMOVE) begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_TASKS; g++) begin : g_cell
      aps_pkg::entry_t nbr;
      if (g < MAX_TASKS - 1) begin : g_mid
        assign nbr = ent_w[g+1];
      end else begin : g_end
        assign nbr = '0;
      end
      aps_cell #(
        .MAX_TASKS (MAX_TASKS),
        .IDX       (g)
      ) u_cell (
        .clk          (clk),
        .cmd          (cmd),
        .count        (count_r),
        .sel_idx      (widx_w[MAX_TASKS]),
        .last_idx     (last_idx),
        .carry        (result.ent),
        .nbr          (nbr),
        .ent          (ent_w[g]),
        .wave_in      (wave_w[g]),
        .wave_in_idx  (widx_w[g]),
        .wave_out     (wave_w[g+1]),
        .wave_out_idx (widx_w[g+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (out_valid_r && out_ready && state_r != S_COMMIT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= in_operation;
            id_r       <= in_task_id;
            prio_r     <= in_priority_req;
            scan_cnt_r <= '0;
            // add needs no search
            if (in_operation == aps_pkg::OP_ADD) state_r <= S_COMMIT;
            else                                  state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_cnt_r == SCAN_LAST) begin
            state_r <= S_COMMIT;
          end else begin
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end
        end
        S_COMMIT: begin
          if (can_out) begin
            out_valid_r <= 1'b1;
            status_r    <= status_c;
            if (op_r == aps_pkg::OP_SELECT && success) begin
              chosen_id_r   <= result.ent.id;
              chosen_prio_r <= result.ent.stat;
            end else begin
              chosen_id_r   <= '0;
              chosen_prio_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_chosen_id       = chosen_id_r;
  assign out_chosen_priority = chosen_prio_r;

endmodule
